// ===== design/soga_pkg.sv =====
// Shared types, codes and constants of the slope occupancy grid accumulator.
package soga_pkg;

  localparam int MaxColsDef   = 256;
  localparam int MaxRowsDef   = 256;
  localparam int CountBitsDef = 16;

  localparam int CoordW  = 16;
  localparam int CsW     = 12;
  localparam int GridW   = 9;
  localparam int ThrW    = 15;
  localparam int IdxW    = 2 * GridW;
  localparam int CfgIdxW = 3;
  localparam int CfgW    = 16;
  localparam int StatusW = 2;
  localparam int OccW    = 7;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ORIGIN_X  = 3'd0,
    CFG_ORIGIN_Y  = 3'd1,
    CFG_CELL_SIZE = 3'd2,
    CFG_CELLS_X   = 3'd3,
    CFG_CELLS_Y   = 3'd4,
    CFG_STEEP_THR = 3'd5,
    CFG_OCC_COUNT = 3'd6
  } cfg_reg_t;

  typedef enum logic [StatusW-1:0] {
    ST_COUNTED = 2'd0,
    ST_DROPPED = 2'd1,
    ST_OUTSIDE = 2'd2,
    ST_READ    = 2'd3
  } status_t;

  localparam logic [OccW-1:0] OCC_VALUE = 7'd100;

  localparam logic signed [CoordW-1:0] ORIGIN_RST    = 16'sd0;
  localparam logic [CsW-1:0]           CELL_SIZE_RST = 12'd20;
  localparam logic [GridW-1:0]         CELLS_RST     = 9'd256;
  localparam logic [ThrW-1:0]          STEEP_RST     = 15'd23170;
  localparam logic signed [CfgW-1:0]   OCC_RST       = 16'sd5;

  typedef struct packed {
    logic load;
    logic clr;
    logic div_start;
    logic div_y;
    logic cap_x;
    logic cap_y;
    logic mul;
    logic addr_pt;
    logic addr_rd;
    logic upd;
    logic res_drop;
    logic res_out;
  } cmd_t;

  typedef struct packed {
    logic is_read;
    logic normal_ok;
    logic neg;
    logic rd_ok;
    logic pt_ok;
    logic div_busy;
    logic clr_done;
    logic out_free;
  } sts_t;

endpackage

// ===== design/soga_div.sv =====
// Iterative unsigned divider, two quotient bits per cycle.
module soga_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [soga_pkg::CoordW-1:0]   dividend,
  input  logic [soga_pkg::CsW-1:0]      divisor,
  output logic [soga_pkg::CoordW-1:0]   quotient,
  output logic                          busy
);
  import soga_pkg::*;

  localparam int Steps = CoordW / 2;
  localparam int StepW = $clog2(Steps);

  logic [CsW-1:0]    rem;
  logic [CoordW-1:0] quo;
  logic [StepW-1:0]  steps;
  logic [CsW:0]      t1, t2;
  logic              ge1, ge2;
  logic [CsW-1:0]    r1, r2;
  logic [CoordW-1:0] q1, q2;

  always_comb begin
    t1  = {rem, quo[CoordW-1]};
    ge1 = t1 >= {1'b0, divisor};
    r1  = ge1 ? CsW'(t1 - {1'b0, divisor}) : t1[CsW-1:0];
    q1  = {quo[CoordW-2:0], ge1};
    t2  = {r1, q1[CoordW-1]};
    ge2 = t2 >= {1'b0, divisor};
    r2  = ge2 ? CsW'(t2 - {1'b0, divisor}) : t2[CsW-1:0];
    q2  = {q1[CoordW-2:0], ge2};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      steps <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      steps <= '0;
    end else if (busy) begin
      steps <= steps + 1'b1;
      if (steps == StepW'(Steps - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      rem <= r2;
      quo <= q2;
    end
  end

  assign quotient = quo;

endmodule

// ===== design/soga_dp.sv =====
// Datapath: configuration registers, binning, counter store and result register.
module soga_dp #(
  parameter int MAX_COLS   = soga_pkg::MaxColsDef,
  parameter int MAX_ROWS   = soga_pkg::MaxRowsDef,
  parameter int COUNT_BITS = soga_pkg::CountBitsDef
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [soga_pkg::CfgIdxW-1:0]        cfg_addr,
  input  logic [soga_pkg::CfgW-1:0]           cfg_data,
  input  logic                                kind,
  input  logic signed [soga_pkg::CoordW-1:0]  point_x,
  input  logic signed [soga_pkg::CoordW-1:0]  point_y,
  input  logic signed [soga_pkg::CoordW-1:0]  surface_nz,
  input  logic                                normal_valid,
  input  logic [soga_pkg::CoordW-1:0]         cell_index,
  input  soga_pkg::cmd_t                      cmd,
  output soga_pkg::sts_t                      sts,
  input  logic                                out_stall,
  output logic                                out_valid,
  output logic [soga_pkg::StatusW-1:0]        status,
  output logic [soga_pkg::OccW-1:0]           occupancy,
  output logic signed [soga_pkg::CfgW-1:0]    cell_count
);
  import soga_pkg::*;

  localparam int Depth = MAX_COLS * MAX_ROWS;
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam logic signed [COUNT_BITS-1:0] CntMax = {1'b0, {(COUNT_BITS-1){1'b1}}};
  localparam logic signed [COUNT_BITS-1:0] CntMin = {1'b1, {(COUNT_BITS-1){1'b0}}};

  logic signed [CoordW-1:0] origin_x, origin_y;
  logic [CsW-1:0]           cell_size;
  logic [GridW-1:0]         cells_x, cells_y;
  logic [ThrW-1:0]          steep_thr;
  logic signed [CfgW-1:0]   occ_thr;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x  <= ORIGIN_RST;
      origin_y  <= ORIGIN_RST;
      cell_size <= CELL_SIZE_RST;
      cells_x   <= CELLS_RST;
      cells_y   <= CELLS_RST;
      steep_thr <= STEEP_RST;
      occ_thr   <= OCC_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_ORIGIN_X:  origin_x  <= cfg_data;
        CFG_ORIGIN_Y:  origin_y  <= cfg_data;
        CFG_CELL_SIZE: cell_size <= cfg_data[CsW-1:0];
        CFG_CELLS_X:   cells_x   <= cfg_data[GridW-1:0];
        CFG_CELLS_Y:   cells_y   <= cfg_data[GridW-1:0];
        CFG_STEEP_THR: steep_thr <= cfg_data[ThrW-1:0];
        CFG_OCC_COUNT: occ_thr   <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [GridW-1:0] cols, rows;
  logic [CsW-1:0]   cs;
  logic [IdxW-1:0]  grid_cells;

  assign cols = ({4'b0, cells_x} < 13'(MAX_COLS)) ? cells_x : GridW'(MAX_COLS);
  assign rows = ({4'b0, cells_y} < 13'(MAX_ROWS)) ? cells_y : GridW'(MAX_ROWS);
  assign cs   = (cell_size == '0) ? CsW'(1) : cell_size;
  assign grid_cells = IdxW'(cols) * IdxW'(rows);

  logic [CoordW:0] dx_full, dy_full, nz_ext, mag;

  assign dx_full = {point_x[CoordW-1], point_x} - {origin_x[CoordW-1], origin_x};
  assign dy_full = {point_y[CoordW-1], point_y} - {origin_y[CoordW-1], origin_y};
  assign nz_ext  = {surface_nz[CoordW-1], surface_nz};
  assign mag     = nz_ext[CoordW] ? ((CoordW+1)'(0) - nz_ext) : nz_ext;

  logic              kind_r, nvalid_r, steep_r, neg_r;
  logic [CoordW-1:0] dx_r, dy_r, cidx_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r   <= kind;
      nvalid_r <= normal_valid;
      steep_r  <= mag < {2'b0, steep_thr};
      neg_r    <= dx_full[CoordW] | dy_full[CoordW];
      dx_r     <= dx_full[CoordW-1:0];
      dy_r     <= dy_full[CoordW-1:0];
      cidx_r   <= cell_index;
    end
  end

  logic [CoordW-1:0] quo, xq, yq;
  logic              div_busy;

  soga_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (cmd.div_y ? dy_r : dx_r),
    .divisor  (cs),
    .quotient (quo),
    .busy     (div_busy)
  );

  logic [IdxW-1:0] prod, idx_r;

  always_ff @(posedge clk) begin
    if (cmd.cap_x) begin
      xq <= quo;
    end
    if (cmd.cap_y) begin
      yq <= quo;
    end
    if (cmd.mul) begin
      prod <= IdxW'(yq[GridW-1:0]) * IdxW'(cols);
    end
    if (cmd.addr_rd) begin
      idx_r <= IdxW'(cidx_r);
    end else if (cmd.addr_pt) begin
      idx_r <= prod + IdxW'(xq[GridW-1:0]);
    end
  end

  logic signed [COUNT_BITS-1:0] mem [Depth];
  logic signed [COUNT_BITS-1:0] rdata, new_cnt, wdata;
  logic [AddrW:0]               clr_cnt;
  logic                         clr_done, mem_we, occ_hit;
  logic [AddrW-1:0]             rd_addr, wr_addr;

  assign clr_done = clr_cnt == (AddrW+1)'(Depth);
  assign rd_addr  = AddrW'(idx_r);
  assign wr_addr  = cmd.clr ? clr_cnt[AddrW-1:0] : rd_addr;
  assign mem_we   = (cmd.clr && !clr_done) || cmd.upd;

  always_comb begin
    if (steep_r) begin
      new_cnt = (rdata == CntMax) ? rdata : rdata + 1'b1;
    end else begin
      new_cnt = (rdata == CntMin) ? rdata : rdata - 1'b1;
    end
  end

  assign wdata   = (cmd.clr || kind_r) ? '0 : new_cnt;
  assign occ_hit = 33'(rdata) > 33'(occ_thr);

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr && !clr_done) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[rd_addr];
    if (mem_we) begin
      mem[wr_addr] <= wdata;
    end
  end

  status_t status_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.upd || cmd.res_drop || cmd.res_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    priority if (cmd.upd) begin
      status_r   <= kind_r ? ST_READ : ST_COUNTED;
      occupancy  <= (kind_r && occ_hit) ? OCC_VALUE : '0;
      cell_count <= kind_r ? CfgW'(rdata) : CfgW'(new_cnt);
    end else if (cmd.res_drop) begin
      status_r   <= ST_DROPPED;
      occupancy  <= '0;
      cell_count <= '0;
    end else if (cmd.res_out) begin
      status_r   <= ST_OUTSIDE;
      occupancy  <= '0;
      cell_count <= '0;
    end else begin
      status_r   <= status_r;
    end
  end

  assign status = status_r;

  always_comb begin
    sts.is_read   = kind_r;
    sts.normal_ok = nvalid_r;
    sts.neg       = neg_r;
    sts.rd_ok     = IdxW'(cidx_r) < grid_cells;
    sts.pt_ok     = (xq < CoordW'(cols)) && (yq < CoordW'(rows));
    sts.div_busy  = div_busy;
    sts.clr_done  = clr_done;
    sts.out_free  = !out_valid || !out_stall;
  end

endmodule

// ===== design/soga_ctrl.sv =====
// Controller state machine sequencing clearing, binning and counter updates.
module soga_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  soga_pkg::sts_t sts,
  output soga_pkg::cmd_t cmd
);
  import soga_pkg::*;

  typedef enum logic [10:0] {
    S_CLEAR   = 11'b000_0000_0001,
    S_IDLE    = 11'b000_0000_0010,
    S_CHECK   = 11'b000_0000_0100,
    S_DIVX    = 11'b000_0000_1000,
    S_DIVY    = 11'b000_0001_0000,
    S_RANGE   = 11'b000_0010_0000,
    S_ADDR    = 11'b000_0100_0000,
    S_MEMRD   = 11'b000_1000_0000,
    S_UPDATE  = 11'b001_0000_0000,
    S_DROP    = 11'b010_0000_0000,
    S_OUTSIDE = 11'b100_0000_0000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = state != S_IDLE;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        priority if (sts.is_read) begin
          if (sts.rd_ok) begin
            cmd.addr_rd = 1'b1;
            state_next  = S_MEMRD;
          end else begin
            state_next = S_OUTSIDE;
          end
        end else if (!sts.normal_ok) begin
          state_next = S_DROP;
        end else if (sts.neg) begin
          state_next = S_OUTSIDE;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_DIVX;
        end
      end
      S_DIVX: begin
        if (!sts.div_busy) begin
          cmd.cap_x     = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_y     = 1'b1;
          state_next    = S_DIVY;
        end
      end
      S_DIVY: begin
        cmd.div_y = 1'b1;
        if (!sts.div_busy) begin
          cmd.cap_y  = 1'b1;
          state_next = S_RANGE;
        end
      end
      S_RANGE: begin
        if (sts.pt_ok) begin
          cmd.mul    = 1'b1;
          state_next = S_ADDR;
        end else begin
          state_next = S_OUTSIDE;
        end
      end
      S_ADDR: begin
        cmd.addr_pt = 1'b1;
        state_next  = S_MEMRD;
      end
      S_MEMRD: begin
        if (sts.out_free) begin
          state_next = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd.upd    = 1'b1;
        state_next = S_IDLE;
      end
      S_DROP: begin
        if (sts.out_free) begin
          cmd.res_drop = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_OUTSIDE: begin
        if (sts.out_free) begin
          cmd.res_out = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== design/slope_occupancy_grid_accumulator_unit.sv =====
// Top level of the slope occupancy grid accumulator.
//
// Requests arrive on in_valid/in_stall: kind 0 bins a point into the grid and
// steps that cell's saturating counter up (steep surface) or down; kind 1
// reads a cell, reports occupancy against CFG_OCC_COUNT and clears it.
// Every request yields exactly one result on out_valid/out_stall.
// Configuration is written through cfg_we/cfg_addr/cfg_data, one register
// per cycle; the user writes it only while no request is in flight, as the
// block itself does not enforce this. A point request is binned by the
// shared divider, which forms the column and then the row quotient at two
// bits per cycle; reads, dropped requests and points left of or below the
// origin skip the divider, while a point beyond the far edge of the grid is
// reported after both divisions. One request is in flight at a time; the
// next is taken in the cycle after the result loads.
// The result register holds while out_stall is high; the block may accept
// the next request meanwhile, and waits before loading its result.
// Reset restores the register defaults and then clears the counter store
// one cell a cycle, all MAX_COLS*MAX_ROWS cells (65536 by default), with
// in_stall held high; configuration writes are taken during that pass.
module slope_occupancy_grid_accumulator_unit #(
  parameter int MAX_COLS   = soga_pkg::MaxColsDef,
  parameter int MAX_ROWS   = soga_pkg::MaxRowsDef,
  parameter int COUNT_BITS = soga_pkg::CountBitsDef
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [soga_pkg::CfgIdxW-1:0]        cfg_addr,
  input  logic [soga_pkg::CfgW-1:0]           cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                kind,
  input  logic signed [soga_pkg::CoordW-1:0]  point_x,
  input  logic signed [soga_pkg::CoordW-1:0]  point_y,
  input  logic signed [soga_pkg::CoordW-1:0]  surface_nz,
  input  logic                                normal_valid,
  input  logic [soga_pkg::CoordW-1:0]         cell_index,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [soga_pkg::StatusW-1:0]        status,
  output logic [soga_pkg::OccW-1:0]           occupancy,
  output logic signed [soga_pkg::CfgW-1:0]    cell_count
);
  import soga_pkg::*;

  cmd_t cmd;
  sts_t sts;

  soga_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  soga_dp #(
    .MAX_COLS   (MAX_COLS),
    .MAX_ROWS   (MAX_ROWS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_data     (cfg_data),
    .kind         (kind),
    .point_x      (point_x),
    .point_y      (point_y),
    .surface_nz   (surface_nz),
    .normal_valid (normal_valid),
    .cell_index   (cell_index),
    .cmd          (cmd),
    .sts          (sts),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .status       (status),
    .occupancy    (occupancy),
    .cell_count   (cell_count)
  );

  a_clear_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> in_stall)
    else $error("request taken before the store was cleared");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second request taken while one is in flight");

  a_update_free: assert property (@(posedge clk) disable iff (rst)
    cmd.upd |-> !out_valid)
    else $error("counter update while an earlier result is still pending");

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    sts.div_busy |-> in_stall)
    else $error("divider busy while the block takes requests");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the slope occupancy grid accumulator.
module testbench;
  import soga_pkg::*;

  localparam int StoreDepth = MaxColsDef * MaxRowsDef;
  localparam int CountMax   = (1 << (CountBitsDef - 1)) - 1;
  localparam int CountMin   = -(1 << (CountBitsDef - 1));

  typedef struct packed {
    logic                     kind;
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
    logic signed [CoordW-1:0] surface_nz;
    logic                     normal_valid;
    logic [CoordW-1:0]        cell_index;
  } grid_req_t;

  typedef struct packed {
    status_t                st;
    logic [OccW-1:0]        occ;
    logic signed [CfgW-1:0] count;
  } grid_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_addr = '0;
  logic [CfgW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic kind = 1'b0;
  logic signed [CoordW-1:0] point_x = '0;
  logic signed [CoordW-1:0] point_y = '0;
  logic signed [CoordW-1:0] surface_nz = '0;
  logic normal_valid = 1'b0;
  logic [CoordW-1:0] cell_index = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [StatusW-1:0] status;
  logic [OccW-1:0] occupancy;
  logic signed [CfgW-1:0] cell_count;

  int cell_store [StoreDepth];
  logic signed [CoordW-1:0] m_origin_x = ORIGIN_RST;
  logic signed [CoordW-1:0] m_origin_y = ORIGIN_RST;
  logic [CsW-1:0] m_cell_size = CELL_SIZE_RST;
  logic [GridW-1:0] m_cells_x = CELLS_RST;
  logic [GridW-1:0] m_cells_y = CELLS_RST;
  logic [ThrW-1:0] m_steep_thr = STEEP_RST;
  logic signed [CfgW-1:0] m_occ_count = OCC_RST;

  grid_res_t pending_results [$];
  int mismatch_count = 0;
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  int hold_off_len = 0;

  slope_occupancy_grid_accumulator_unit u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .kind         (kind),
    .point_x      (point_x),
    .point_y      (point_y),
    .surface_nz   (surface_nz),
    .normal_valid (normal_valid),
    .cell_index   (cell_index),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .occupancy    (occupancy),
    .cell_count   (cell_count)
  );

  always #5 clk = ~clk;

  function automatic int unsigned pick_gap();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic grid_res_t accumulate_request(input grid_req_t r);
    int cols, rows, dx, dy, mag, cs, xc, yc, idx, cnt;
    grid_res_t res;
    cols = (int'(m_cells_x) < MaxColsDef) ? int'(m_cells_x) : MaxColsDef;
    rows = (int'(m_cells_y) < MaxRowsDef) ? int'(m_cells_y) : MaxRowsDef;
    res.st = ST_OUTSIDE;
    res.occ = '0;
    res.count = '0;
    if (r.kind) begin
      idx = int'(r.cell_index);
      if (idx < cols * rows) begin
        cnt = cell_store[idx];
        cell_store[idx] = 0;
        res.st = ST_READ;
        res.occ = (cnt > int'(m_occ_count)) ? OCC_VALUE : '0;
        res.count = 16'(cnt);
      end
    end else if (!r.normal_valid) begin
      res.st = ST_DROPPED;
    end else begin
      dx = int'(r.point_x) - int'(m_origin_x);
      dy = int'(r.point_y) - int'(m_origin_y);
      mag = (r.surface_nz < 0) ? -int'(r.surface_nz) : int'(r.surface_nz);
      cs = (m_cell_size == '0) ? 1 : int'(m_cell_size);
      if (dx >= 0 && dy >= 0) begin
        xc = dx / cs;
        yc = dy / cs;
        if (xc < cols && yc < rows) begin
          idx = yc * cols + xc;
          cnt = cell_store[idx];
          if (mag < int'(m_steep_thr)) begin
            if (cnt < CountMax) cnt++;
          end else if (cnt > CountMin) begin
            cnt--;
          end
          cell_store[idx] = cnt;
          res.st = ST_COUNTED;
          res.count = 16'(cnt);
        end
      end
    end
    return res;
  endfunction

  function automatic grid_req_t point_req(input int x, input int y, input int nz, input bit nv);
    grid_req_t r;
    r.kind = 1'b0;
    r.point_x = 16'(x);
    r.point_y = 16'(y);
    r.surface_nz = 16'(nz);
    r.normal_valid = nv;
    r.cell_index = 16'($urandom);
    return r;
  endfunction

  function automatic grid_req_t read_req(input int idx);
    grid_req_t r;
    r.kind = 1'b1;
    r.point_x = 16'($urandom);
    r.point_y = 16'($urandom);
    r.surface_nz = 16'($urandom);
    r.normal_valid = 1'($urandom);
    r.cell_index = 16'(idx);
    return r;
  endfunction

  function automatic grid_req_t random_request();
    grid_req_t r;
    int unsigned pick;
    int cols, rows, cs, xv, yv, nzv;
    cols = (int'(m_cells_x) < MaxColsDef) ? int'(m_cells_x) : MaxColsDef;
    rows = (int'(m_cells_y) < MaxRowsDef) ? int'(m_cells_y) : MaxRowsDef;
    cs = (m_cell_size == '0) ? 1 : int'(m_cell_size);
    r.kind = 1'b0;
    r.point_x = 16'($urandom);
    r.point_y = 16'($urandom);
    r.surface_nz = 16'($urandom);
    r.normal_valid = 1'b1;
    r.cell_index = 16'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 18) begin
      r.kind = 1'b1;
      if (pick < 15) r.cell_index = 16'($urandom_range(0, cols * rows));
    end else if (pick < 23) begin
      r.normal_valid = 1'b0;
    end else if (pick >= 33) begin
      xv = int'(m_origin_x) + int'($urandom_range(0, cols)) * cs + int'($urandom_range(0, cs - 1));
      yv = int'(m_origin_y) + int'($urandom_range(0, rows)) * cs + int'($urandom_range(0, cs - 1));
      if (xv >= -32768 && xv <= 32767) r.point_x = 16'(xv);
      if (yv >= -32768 && yv <= 32767) r.point_y = 16'(yv);
      if ($urandom_range(0, 1) == 0) begin
        nzv = int'(m_steep_thr) + int'($urandom_range(0, 6)) - 3;
        if ($urandom_range(0, 1) == 0) nzv = -nzv;
        r.surface_nz = 16'(nzv);
      end
    end
    return r;
  endfunction

  task automatic send_request(input grid_req_t r);
    int unsigned gap;
    gap = tx_idle_on ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    kind <= r.kind;
    point_x <= r.point_x;
    point_y <= r.point_y;
    surface_nz <= r.surface_nz;
    normal_valid <= r.normal_valid;
    cell_index <= r.cell_index;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(accumulate_request(r));
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t sel, input logic [CfgW-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= sel;
    cfg_data <= value;
    @(posedge clk);
    unique case (sel)
      CFG_ORIGIN_X: m_origin_x = value;
      CFG_ORIGIN_Y: m_origin_y = value;
      CFG_CELL_SIZE: m_cell_size = value[CsW-1:0];
      CFG_CELLS_X: m_cells_x = value[GridW-1:0];
      CFG_CELLS_Y: m_cells_y = value[GridW-1:0];
      CFG_STEEP_THR: m_steep_thr = value[ThrW-1:0];
      CFG_OCC_COUNT: m_occ_count = value;
      default: ;
    endcase
  endtask

  task automatic set_grid(input int ox, input int oy, input int cs, input int cx, input int cy,
                          input int thr, input int occ);
    write_reg(CFG_ORIGIN_X, 16'(ox));
    write_reg(CFG_ORIGIN_Y, 16'(oy));
    write_reg(CFG_CELL_SIZE, 16'(cs));
    write_reg(CFG_CELLS_X, 16'(cx));
    write_reg(CFG_CELLS_Y, 16'(cy));
    write_reg(CFG_STEEP_THR, 16'(thr));
    write_reg(CFG_OCC_COUNT, 16'(occ));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic test_directed_points();
    send_request(point_req(0, 0, 0, 1'b1));
    send_request(point_req(5, 5, 23169, 1'b1));
    send_request(point_req(19, 19, 23170, 1'b1));
    send_request(point_req(0, 0, -32768, 1'b1));
    send_request(point_req(0, 0, 32767, 1'b1));
    send_request(point_req(0, 0, -23169, 1'b1));
    send_request(point_req(0, 0, 0, 1'b0));
    send_request(point_req(-1, 0, 0, 1'b1));
    send_request(point_req(0, -1, 0, 1'b1));
    send_request(point_req(-32768, 32767, 0, 1'b1));
    send_request(point_req(5119, 5119, 0, 1'b1));
    send_request(point_req(5120, 0, 0, 1'b1));
    send_request(point_req(0, 5120, 0, 1'b1));
    send_request(point_req(32767, 32767, 0, 1'b1));
    send_request(read_req(65535));
    send_request(read_req(0));
    send_request(read_req(0));
  endtask

  task automatic test_config_extremes();
    wait_idle();
    set_grid(-32768, -32768, 4095, 511, 511, 32767, -32768);
    send_request(point_req(32767, 32767, 0, 1'b1));
    send_request(point_req(32767, 32767, 32767, 1'b1));
    send_request(point_req(-32768, -32768, -32768, 1'b1));
    send_request(point_req(-32768, -32768, 32766, 1'b1));
    send_request(read_req(16 * 256 + 16));
    send_request(read_req(0));
    send_request(read_req(65535));
    wait_idle();
    set_grid(0, 0, 0, 0, 5, 23170, 0);
    send_request(point_req(3, 3, 0, 1'b1));
    send_request(read_req(0));
    wait_idle();
    set_grid(0, 0, 0, 5, 0, 23170, 0);
    send_request(point_req(3, 3, 0, 1'b1));
    wait_idle();
    set_grid(32767, 32767, 1, 1, 1, 0, 32767);
    send_request(point_req(32767, 32767, 0, 1'b1));
    send_request(point_req(32766, 32767, 0, 1'b1));
    send_request(read_req(1));
    send_request(read_req(0));
    wait_idle();
    // count equal to the occupancy level reads as free
    set_grid(100, -100, 7, 3, 2, 16384, 1);
    send_request(point_req(120, -93, 100, 1'b1));
    send_request(read_req(5));
    send_request(point_req(114, -87, -100, 1'b1));
    send_request(point_req(116, -94, 0, 1'b1));
    send_request(read_req(5));
    send_request(point_req(121, -100, 0, 1'b1));
    send_request(point_req(100, -86, 0, 1'b1));
    send_request(read_req(6));
  endtask

  task automatic test_backpressure();
    wait_idle();
    tx_idle_on = 1'b0;
    hold_off_len = 400;
    repeat (30) send_request(random_request());
    tx_idle_on = 1'b1;
  endtask

  task automatic test_random_phases();
    int ox, oy, cs, cx, cy;
    for (int phase = 0; phase < 6; phase++) begin
      wait_idle();
      tx_idle_on = (phase != 2);
      rx_idle_on = (phase != 3);
      ox = ($urandom_range(0, 3) == 0) ? int'($urandom) : int'($urandom_range(0, 4000)) - 2000;
      oy = ($urandom_range(0, 3) == 0) ? int'($urandom) : int'($urandom_range(0, 4000)) - 2000;
      if (phase == 1) cs = 0;
      else if ($urandom_range(0, 9) == 0) cs = $urandom_range(65, 4095);
      else cs = $urandom_range(1, 64);
      cx = (phase == 5) ? $urandom_range(200, 511) : $urandom_range(1, 12);
      cy = (phase == 5) ? $urandom_range(200, 511) : $urandom_range(1, 12);
      set_grid(ox, oy, cs, cx, cy, $urandom_range(0, 32767), int'($urandom_range(0, 6)) - 3);
      repeat (200) send_request(random_request());
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  task automatic test_counter_walk();
    wait_idle();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    set_grid(0, 0, 1, 1, 1, 16384, 2);
    repeat (25) send_request(point_req(0, 0, 0, 1'b1));
    send_request(read_req(0));
    repeat (50) send_request(point_req(0, 0, 32767, 1'b1));
    send_request(read_req(0));
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  initial begin
    forever begin
      @(negedge clk);
      if (hold_off_len > 0) begin
        out_stall <= 1'b1;
        repeat (hold_off_len) @(negedge clk);
        hold_off_len = 0;
        out_stall <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat (pick_gap() + 1) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    grid_res_t want;
    if (!rst && out_valid === 1'b1 && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding: status %0d count %0d", status, cell_count);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (status !== want.st) begin
          $error("status: expected %0d, got %0d", want.st, status);
          mismatch_count++;
        end
        if (occupancy !== want.occ) begin
          $error("occupancy: expected %0d, got %0d", want.occ, occupancy);
          mismatch_count++;
        end
        if (cell_count !== want.count) begin
          $error("cell_count: expected %0d, got %0d", want.count, cell_count);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    #40000000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    test_directed_points();
    test_config_extremes();
    test_backpressure();
    test_random_phases();
    test_counter_walk();
    wait_idle();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
